// ===== hdl/radius2_torus_automaton_step_top_macros.svh =====
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef RADIUS2_TORUS_AUTOMATON_STEP_TOP_MACROS_SVH
`define RADIUS2_TORUS_AUTOMATON_STEP_TOP_MACROS_SVH

// Same-cycle implication.
`define RTAS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RTAS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rtas_pkg.sv =====
package rtas_pkg;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } state_t;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_GEN  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    localparam logic [2:0] CELL_EMPTY    = 3'd0;
    localparam logic [2:0] CELL_EGG      = 3'd1;
    localparam logic [2:0] CELL_JUVENILE = 3'd2;
    localparam logic [2:0] CELL_ADULT    = 3'd3;
    localparam logic [2:0] CELL_OTHER    = 3'd4;

    // One window column: adults in its five rows, plus its middle-row code.
    typedef struct packed
    {
        logic [2:0] cnt;
        logic [2:0] ctr;
    } col_t;

    function automatic logic [2:0] load_code(input logic [7:0] raw);
        logic [2:0] code;
        code = (raw > 8'd3) ? CELL_OTHER : raw[2:0];
        return code;
    endfunction

    function automatic logic [2:0] next_cell(input logic [2:0] here,
                                             input logic [4:0] adults);
        logic [2:0] nxt;
        case (here)
            CELL_EMPTY:
                nxt = (adults >= 5'd3 && adults <= 5'd5) ? CELL_EGG : CELL_EMPTY;
            CELL_EGG:
                nxt = CELL_JUVENILE;
            CELL_JUVENILE:
                nxt = CELL_ADULT;
            CELL_ADULT:
                nxt = (adults >= 5'd4 && adults <= 5'd9) ? CELL_ADULT : CELL_EMPTY;
            default:
                nxt = CELL_EMPTY;
        endcase
        return nxt;
    endfunction

endpackage

// ===== hdl/rtas_ram.sv =====
module rtas_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/rtas_cell.sv =====
module rtas_cell
    import rtas_pkg::*;
(
    input  logic clk,
    input  logic shift,
    input  col_t d,
    output col_t q
);

    col_t col_reg;

    // window slot; takes its neighbour's column on each shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= d;
        end
    end

    assign q = col_reg;

endmodule

// ===== hdl/radius2_torus_automaton_step_top.sv =====
// Radius-2 larger-than-life automaton on a square torus of side 2**side_log2
// (capped at 2**MAX_SIDE_LOG2), held in two ping-pong banks of single-port-read
// RAM. The s_tuser action picks the operation: load (no result), read (result
// word with m_tuser 0 and the cell code) or one generation (result word with
// m_tuser 1, code 0, once the new bank has been written and made current).
// Loads and reads are taken one word per cycle while idle and while no read's code
// waits for a busy output register; a read's code reaches the output register once
// that is free. A generation scans the grid row by row through a chain of five
// column cells: each window column costs five reads of the source bank's single
// read port, each row needs side+4 columns, and no word is taken meanwhile. Every
// cell must be loaded before the first generation; out-of-range coordinates wrap.
// The user writes side_log2 over APB at address 0 only while idle; not enforced.
`include "radius2_torus_automaton_step_top_macros.svh"

module radius2_torus_automaton_step_top
    import rtas_pkg::*;
#(
    parameter int MAX_SIDE_LOG2 = 7
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // col[6:0], row[13:7], load_value[21:14], zero
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // cell_code[2:0], zero
    output logic        m_tuser,   // kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW    = MAX_SIDE_LOG2;
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int LW    = $clog2(MAX_SIDE_LOG2 + 1);

    // ---------------- configuration ----------------
    logic [2:0] side_log2_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, side_log2_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_log2_reg <= 3'd7;
        end
        else if (psel && penable && pwrite && (paddr[2] == 1'b0))
        begin
            side_log2_reg <= pwdata[2:0];
        end
    end

    logic [LW-1:0] lg;
    logic [CW:0]   side_w;
    logic [CW-1:0] mask;

    assign lg     = (32'(side_log2_reg) > MAX_SIDE_LOG2) ? LW'(MAX_SIDE_LOG2)
                                                         : LW'(side_log2_reg);
    assign side_w = (CW+1)'(1) << lg;
    assign mask   = CW'(side_w - (CW+1)'(1));

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c,
                                                input logic [CW-1:0] m,
                                                input logic [LW-1:0] l);
        logic [AW-1:0] a;
        a = (AW'(r & m) << l) | AW'(c & m);
        return a;
    endfunction

    // ---------------- input decode ----------------
    logic [1:0]    action;
    logic [CW-1:0] in_col;
    logic [CW-1:0] in_row;
    logic [7:0]    in_val;
    logic          accept;
    logic [AW-1:0] in_addr;

    assign action  = s_tuser;
    assign in_col  = CW'(s_tdata[6:0]);
    assign in_row  = CW'(s_tdata[13:7]);
    assign in_val  = s_tdata[21:14];
    assign accept  = s_tvalid && s_tready;
    assign in_addr = cell_addr(in_row, in_col, mask, lg);

    // ---------------- control state ----------------
    state_t        state_reg, state_next;
    logic          cur_reg, cur_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] y_reg, y_next;
    logic [CW:0]   c_reg, c_next;
    logic [2:0]    dy_reg, dy_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic          kind_reg, kind_next;
    logic [2:0]    code_reg, code_next;

    logic          out_free;
    logic          issue;
    logic          issue_fin;
    logic          last_col;
    logic [CW-1:0] scan_row;
    logic [CW-1:0] scan_col;
    logic [AW-1:0] scan_addr;

    // read pipeline of the scan
    logic          gen_rv_reg;
    logic          rd_fin_reg;
    logic [2:0]    rd_dy_reg;
    logic [CW:0]   rd_c_reg;
    logic [CW-1:0] rd_y_reg;
    logic          push;

    // write-back stage
    logic          wr_v_reg;
    logic          wr_fin_reg;
    logic [CW-1:0] wr_x_reg;
    logic [CW-1:0] wr_y_reg;

    logic [2:0] src_data;
    logic [2:0] rda;
    logic [2:0] rdb;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && (!pend_reg || out_free);
    assign last_col  = (c_reg == side_w + (CW+1)'(3));
    assign issue     = (state_reg == ST_SCAN);
    assign issue_fin = issue && (dy_reg == 3'd4) && last_col && (y_reg == mask);
    assign scan_row  = y_reg + CW'(dy_reg) - CW'(2);
    assign scan_col  = CW'(c_reg) - CW'(2);
    assign scan_addr = cell_addr(scan_row, scan_col, mask, lg);
    assign src_data  = cur_reg ? rdb : rda;

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        pend_next     = pend_reg;
        y_next        = y_reg;
        c_next        = c_reg;
        dy_next       = dy_reg;
        m_tvalid_next = m_tvalid_reg;
        kind_next     = kind_reg;
        code_next     = code_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        // a pending read moves its code into the output register
        if (pend_reg && out_free)
        begin
            m_tvalid_next = 1'b1;
            kind_next     = KIND_READ;
            code_next     = src_data;
            pend_next     = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_READ)
                begin
                    pend_next = 1'b1;
                end
                if (accept && action == ACT_GEN)
                begin
                    y_next     = '0;
                    c_next     = '0;
                    dy_next    = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (dy_reg == 3'd4)
                begin
                    dy_next = '0;
                    if (last_col)
                    begin
                        c_next = '0;
                        y_next = y_reg + CW'(1);
                        if (y_reg == mask)
                        begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + (CW+1)'(1);
                    end
                end
                else
                begin
                    dy_next = dy_reg + 3'd1;
                end
            end
            ST_FLUSH:
            begin
                // last write-back happens this cycle: swap banks
                if (wr_v_reg && wr_fin_reg)
                begin
                    cur_next   = !cur_reg;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    kind_next     = KIND_DONE;
                    code_next     = CELL_EMPTY;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cur_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            gen_rv_reg   <= 1'b0;
            rd_fin_reg   <= 1'b0;
            wr_v_reg     <= 1'b0;
            wr_fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
            gen_rv_reg   <= issue;
            rd_fin_reg   <= issue_fin;
            wr_v_reg     <= push && (rd_c_reg >= (CW+1)'(4));
            wr_fin_reg   <= push && rd_fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg     <= y_next;
        c_reg     <= c_next;
        dy_reg    <= dy_next;
        kind_reg  <= kind_next;
        code_reg  <= code_next;
        rd_dy_reg <= dy_reg;
        rd_c_reg  <= c_reg;
        rd_y_reg  <= y_reg;
        if (push)
        begin
            wr_x_reg <= CW'(rd_c_reg - (CW+1)'(4));
            wr_y_reg <= rd_y_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {5'd0, code_reg};

    // ---------------- column accumulation ----------------
    logic       adult;
    logic [2:0] acc_cnt_reg;
    logic [2:0] acc_ctr_reg;
    col_t       push_col;

    assign adult = (src_data == CELL_ADULT);
    assign push  = gen_rv_reg && (rd_dy_reg == 3'd4);

    assign push_col.cnt = acc_cnt_reg + {2'd0, adult};
    assign push_col.ctr = acc_ctr_reg;

    always_ff @(posedge clk)
    begin
        if (gen_rv_reg)
        begin
            acc_cnt_reg <= (rd_dy_reg == 3'd0) ? {2'd0, adult}
                                               : acc_cnt_reg + {2'd0, adult};
            if (rd_dy_reg == 3'd2)
            begin
                acc_ctr_reg <= src_data;
            end
        end
    end

    // ---------------- window: chain of five column cells ----------------
    col_t win [5];

    genvar gi;
    generate
        for (gi = 0; gi < 5; gi++)
        begin : g_win
            if (gi == 4)
            begin : g_head
                rtas_cell u_cell (
                    .clk   (clk),
                    .shift (push),
                    .d     (push_col),
                    .q     (win[gi])
                );
            end
            else
            begin : g_body
                rtas_cell u_cell (
                    .clk   (clk),
                    .shift (push),
                    .d     (win[gi+1]),
                    .q     (win[gi])
                );
            end
        end
    endgenerate

    logic [4:0] win_sum;
    logic [4:0] adults;
    logic [2:0] new_code;

    assign win_sum  = 5'(win[0].cnt) + 5'(win[1].cnt) + 5'(win[2].cnt)
                    + 5'(win[3].cnt) + 5'(win[4].cnt);
    assign adults   = win_sum - {4'd0, (win[2].ctr == CELL_ADULT)};
    assign new_code = next_cell(win[2].ctr, adults);

    // ---------------- banks ----------------
    logic          load_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          we_a;
    logic          we_b;
    logic [AW-1:0] waddr_a;
    logic [AW-1:0] waddr_b;
    logic [2:0]    wdata_a;
    logic [2:0]    wdata_b;

    assign load_we = accept && (action == ACT_LOAD);
    assign wr_addr = cell_addr(wr_y_reg, wr_x_reg, mask, lg);
    assign rd_addr = issue ? scan_addr : in_addr;
    assign rd_en   = issue || (accept && action == ACT_READ);

    // the current bank takes loads, the other one takes write-back
    assign we_a    = cur_reg ? wr_v_reg : load_we;
    assign we_b    = cur_reg ? load_we : wr_v_reg;
    assign waddr_a = cur_reg ? wr_addr : in_addr;
    assign waddr_b = cur_reg ? in_addr : wr_addr;
    assign wdata_a = cur_reg ? new_code : load_code(in_val);
    assign wdata_b = cur_reg ? load_code(in_val) : new_code;

    rtas_ram #(
        .WIDTH (3),
        .DEPTH (DEPTH)
    ) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr_a),
        .wdata (wdata_a),
        .re    (rd_en && !cur_reg),
        .raddr (rd_addr),
        .rdata (rda)
    );

    rtas_ram #(
        .WIDTH (3),
        .DEPTH (DEPTH)
    ) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr_b),
        .wdata (wdata_b),
        .re    (rd_en && cur_reg),
        .raddr (rd_addr),
        .rdata (rdb)
    );

    // ---------------- assertions ----------------
    `RTAS_ASSERT_NOW(a_wb_in_gen, wr_v_reg, (state_reg == ST_SCAN || state_reg == ST_FLUSH), "write-back outside a generation")
    `RTAS_ASSERT_NOW(a_pend_idle, pend_reg, (state_reg == ST_IDLE), "read pending during a generation")
    `RTAS_ASSERT_NEXT(a_wb_spacing, wr_v_reg, !wr_v_reg, "window pushed faster than one column per five reads")
    `RTAS_ASSERT_NEXT(a_bank_swap, (state_reg != ST_FLUSH), (cur_reg == $past(cur_reg)), "bank swapped outside end of generation")

endmodule
